// ===== design/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_TRIG   = 2'd1,
        PH_LISTEN = 2'd2
    } phase_t;

    localparam logic CFG_TRIGGER_TICKS = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0]  TRIGGER_RESET = 8'd10;
    localparam logic [15:0] TIMEOUT_RESET = 16'd60000;

    // floor(e / 296) = floor((e >> 3) / 37); x / 37 = (x * 7085) >> 18 for x < 8192
    localparam logic [12:0] DIV_MUL   = 13'd7085;
    localparam int          DIV_SHIFT = 18;

    typedef struct packed {
        logic [7:0]  trigger_ticks;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } item_t;

    typedef struct packed {
        logic       trigger_level;
        logic       busy_res;
        logic       done_res;
        logic       timed_out;
        logic [7:0] distance;
    } result_t;

endpackage

// ===== design/uer_if.sv =====
// Channel interfaces for tick samples and ranging results.
interface uer_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_out_if;
    logic       valid;
    logic       ready;
    logic       trigger_level;
    logic       busy_res;
    logic       done_res;
    logic       timed_out;
    logic [7:0] distance;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output timed_out, output distance, input ready);
    modport sink (input valid, input trigger_level, input busy_res, input done_res,
                  input timed_out, input distance, output ready);
endinterface

// ===== design/uer_cfg_regs.sv =====
// Configuration registers: trigger length and listen timeout.
module uer_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [uer_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output uer_pkg::cfg_t                      cfg
);

    logic [7:0]  trigger_reg;
    logic [15:0] timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg <= uer_pkg::TRIGGER_RESET;
            timeout_reg <= uer_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                uer_pkg::CFG_TRIGGER_TICKS: trigger_reg <= cfg_wdata[7:0];
                uer_pkg::CFG_TIMEOUT_TICKS: timeout_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign cfg.trigger_ticks = trigger_reg;
    assign cfg.timeout_ticks = timeout_reg;

endmodule

// ===== design/uer_in_reg.sv =====
// Input register for one tick transaction.
module uer_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    uer_in_if.sink          sample,
    input  logic            advance,
    output logic            item_valid,
    output uer_pkg::item_t  item
);

    logic           valid_reg;
    logic           valid_next;
    uer_pkg::item_t item_reg;
    logic           take;

    assign sample.ready = !valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.start_req  <= sample.start_req;
            item_reg.echo_level <= sample.echo_level;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/uer_core.sv =====
// Ranging state machine, distance scaling and result register.
module uer_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  uer_pkg::cfg_t   cfg,
    input  logic            item_valid,
    input  uer_pkg::item_t  item,
    output logic            advance,
    uer_out_if.source       result
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    uer_pkg::phase_t          phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]   tick_reg, tick_next;
    logic                     echo_seen_reg, echo_seen_next;
    logic [7:0]               dist_reg, dist_next;

    logic                     out_valid_reg;
    uer_pkg::result_t         res_reg;
    uer_pkg::result_t         res_next;

    logic [7:0]               trig_len;
    logic [COUNT_WIDTH-1:0]   cnt_inc;
    logic [31:0]              cnt_ext;
    logic [15:0]              elapsed;
    logic [25:0]              prod;
    logic                     done;
    logic                     tmo;

    assign advance  = item_valid && (!out_valid_reg || result.ready);
    assign trig_len = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;
    assign cnt_inc  = (tick_reg == CNT_MAX) ? tick_reg : tick_reg + COUNT_WIDTH'(1);
    assign cnt_ext  = 32'(cnt_inc);
    assign elapsed  = (cnt_ext > 32'hFFFF) ? 16'hFFFF : cnt_ext[15:0];
    assign prod     = 26'(elapsed[15:3]) * 26'(uer_pkg::DIV_MUL);

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        echo_seen_next = echo_seen_reg;
        dist_next      = dist_reg;
        done           = 1'b0;
        tmo            = 1'b0;
        res_next       = '0;
        unique case (phase_reg)
            uer_pkg::PH_TRIG:
            begin
                res_next.trigger_level = 1'b1;
                res_next.busy_res      = 1'b1;
                tick_next              = cnt_inc;
                if (cnt_ext >= 32'(trig_len))
                begin
                    phase_next     = uer_pkg::PH_LISTEN;
                    tick_next      = '0;
                    echo_seen_next = 1'b0;
                end
            end
            uer_pkg::PH_LISTEN:
            begin
                res_next.busy_res = 1'b1;
                tick_next         = cnt_inc;
                if (item.echo_level)
                    echo_seen_next = 1'b1;
                else if (echo_seen_reg)
                begin
                    dist_next = prod[uer_pkg::DIV_SHIFT +: 8];
                    done      = 1'b1;
                end
                if (!done && (cnt_ext >= 32'(cfg.timeout_ticks) || cnt_inc == CNT_MAX))
                begin
                    done = 1'b1;
                    tmo  = 1'b1;
                end
                if (done)
                begin
                    phase_next     = uer_pkg::PH_IDLE;
                    tick_next      = '0;
                    echo_seen_next = 1'b0;
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
                if (item.start_req)
                begin
                    res_next.trigger_level = 1'b1;
                    res_next.busy_res      = 1'b1;
                    if (trig_len == 8'd1)
                    begin
                        phase_next     = uer_pkg::PH_LISTEN;
                        tick_next      = '0;
                        echo_seen_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = uer_pkg::PH_TRIG;
                        tick_next  = COUNT_WIDTH'(1);
                    end
                end
            end
        endcase
        res_next.done_res  = done;
        res_next.timed_out = tmo;
        res_next.distance  = dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= uer_pkg::PH_IDLE;
            tick_reg      <= '0;
            echo_seen_reg <= 1'b0;
            dist_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                echo_seen_reg <= echo_seen_next;
                dist_reg      <= dist_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.trigger_level = res_reg.trigger_level;
    assign result.busy_res      = res_reg.busy_res;
    assign result.done_res      = res_reg.done_res;
    assign result.timed_out     = res_reg.timed_out;
    assign result.distance      = res_reg.distance;

`ifndef SYNTH
    a_tmo_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.timed_out |-> res_reg.done_res && res_reg.busy_res)
        else $error("timeout reported without done");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && done |=> phase_reg == uer_pkg::PH_IDLE && tick_reg == '0)
        else $error("measurement end did not return to idle");

    a_dist_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !(done && !tmo) |=> dist_reg == $past(dist_reg))
        else $error("distance changed without an echo measurement");

    // trigger length may shrink mid-trigger, so only the absolute bound holds
    a_trig_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == uer_pkg::PH_TRIG |-> tick_reg != '0 && 32'(tick_reg) < 32'd255)
        else $error("trigger count out of range");
`endif

endmodule

// ===== design/ultrasonic_echo_ranger_unit.sv =====
// Top level of the ultrasonic echo ranger.
//
// channel   dir  handshake      payload
// sample    in   valid/ready    start_req, echo_level (one tick)
// result    out  valid/ready    trigger_level, busy_res, done_res, timed_out, distance
// cfg       in   cfg_we         cfg_index, cfg_wdata
//
// One result transaction per sample transaction, one per cycle sustained while result is ready.
// A sample passes the input register, then the state update and result register.
// The distance multiply (13 x 13 bits) sits in the state update stage.
// rst_n clears state to idle with zero distance and loads register defaults.
// A stalled result holds its register; the input register takes one more sample,
// then drops ready until the result is taken.
module ultrasonic_echo_ranger_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    uer_in_if.sink                          sample,
    uer_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    uer_pkg::cfg_t  cfg;
    uer_pkg::item_t item;
    logic           item_valid;
    logic           advance;

    uer_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    uer_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    uer_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .result     (result)
    );

endmodule

// ===== sim/ultrasonic_echo_ranger_unit_test.sv =====
// Self-checking testbench for the ultrasonic echo ranger top level.
`timescale 1ns / 100ps

module ultrasonic_echo_ranger_unit_test;

    localparam int RESET_CYCLES   = 11;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_TICKS    = 40;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata;

    uer_in_if sample_ch ();
    uer_out_if result_ch ();

    ultrasonic_echo_ranger_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // register copies and ranging state of the predictor
    logic [7:0] trig_len;
    logic [15:0] timeout_len;
    uer_pkg::phase_t rng_phase;
    logic [15:0] rng_ticks;
    bit rng_seen;
    logic [7:0] rng_dist;

    uer_pkg::item_t tick_queue[$];
    uer_pkg::result_t exp_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    int ticks_queued;
    int ticks_sent;
    int results_checked;
    int mismatch_count;
    int echo_count;
    int timeout_count;
    int settings_used;
    int max_dist;
    int hold_asked;
    int hold_taken;
    int hold_left;
    int stall_cycles;

    function automatic uer_pkg::result_t ranger_tick(input uer_pkg::item_t smp);
        uer_pkg::result_t r;
        logic [15:0] trig_need;
        logic [15:0] quot;
        r = '0;
        trig_need = (trig_len == 8'd0) ? 16'd1 : {8'd0, trig_len};
        if ((rng_phase == uer_pkg::PH_TRIG || rng_phase == uer_pkg::PH_LISTEN)
            && rng_ticks != 16'hFFFF)
            rng_ticks = rng_ticks + 16'd1;
        case (rng_phase)
            uer_pkg::PH_TRIG:
            begin
                r.trigger_level = 1'b1;
                r.busy_res = 1'b1;
            end
            uer_pkg::PH_LISTEN:
            begin
                r.busy_res = 1'b1;
                if (smp.echo_level)
                    rng_seen = 1'b1;
                else if (rng_seen)
                begin
                    quot = rng_ticks / 16'd296;
                    rng_dist = quot[7:0];
                    r.done_res = 1'b1;
                end
                if (!r.done_res && (rng_ticks >= timeout_len || rng_ticks == 16'hFFFF))
                begin
                    r.done_res = 1'b1;
                    r.timed_out = 1'b1;
                end
                if (r.done_res)
                begin
                    rng_phase = uer_pkg::PH_IDLE;
                    rng_ticks = '0;
                    rng_seen = 1'b0;
                end
            end
            default:
            begin
                rng_phase = uer_pkg::PH_IDLE;
                if (smp.start_req)
                begin
                    r.trigger_level = 1'b1;
                    r.busy_res = 1'b1;
                    rng_phase = uer_pkg::PH_TRIG;
                    rng_ticks = 16'd1;
                end
            end
        endcase
        if (rng_phase == uer_pkg::PH_TRIG && rng_ticks >= trig_need)
        begin
            rng_phase = uer_pkg::PH_LISTEN;
            rng_ticks = '0;
            rng_seen = 1'b0;
        end
        r.distance = rng_dist;
        return r;
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin : drive_samples
        uer_pkg::item_t nxt;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.start_req <= 1'b0;
            sample_ch.echo_level <= 1'b0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                nxt.start_req = sample_ch.start_req;
                nxt.echo_level = sample_ch.echo_level;
                exp_results.push_back(ranger_tick(nxt));
                ticks_sent++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = tick_queue.pop_front();
                    sample_ch.valid <= 1'b1;
                    sample_ch.start_req <= nxt.start_req;
                    sample_ch.echo_level <= nxt.echo_level;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        uer_pkg::result_t got;
        uer_pkg::result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= 0;
            hold_taken <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.trigger_level = result_ch.trigger_level;
                got.busy_res = result_ch.busy_res;
                got.done_res = result_ch.done_res;
                got.timed_out = result_ch.timed_out;
                got.distance = result_ch.distance;
                if (exp_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result transaction: dist %0d", got.distance);
                    mismatch_count++;
                end
                else
                begin
                    want = exp_results.pop_front();
                    results_checked++;
                    if (got.trigger_level !== want.trigger_level
                        || got.busy_res !== want.busy_res
                        || got.done_res !== want.done_res
                        || got.timed_out !== want.timed_out
                        || got.distance !== want.distance)
                    begin
                        if (mismatch_count < 10)
                            $display("mismatch on result %0d (exp/got): trig %b/%b busy %b/%b %s",
                                     results_checked, want.trigger_level, got.trigger_level,
                                     want.busy_res, got.busy_res,
                                     $sformatf("done %b/%b tmo %b/%b dist %0d/%0d",
                                               want.done_res, got.done_res, want.timed_out,
                                               got.timed_out, want.distance, got.distance));
                        mismatch_count++;
                    end
                    if (want.timed_out)
                        timeout_count++;
                    else if (want.done_res)
                        echo_count++;
                    if (int'(want.distance) > max_dist)
                        max_dist = int'(want.distance);
                end
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                result_ch.ready <= 1'b0;
            end
            else if (hold_taken != hold_asked)
            begin
                hold_taken <= hold_asked;
                hold_left <= HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ultrasonic_echo_ranger_unit test failed");
            $finish;
        end
    end

    task automatic push_tick(input bit st, input bit ec);
        uer_pkg::item_t t;
        t.start_req = st;
        t.echo_level = ec;
        tick_queue.push_back(t);
        ticks_queued++;
    endtask

    task automatic push_idle(input int n);
        repeat (n) push_tick(1'b0, 1'($urandom_range(1)));
    endtask

    // start, trigger ticks with ignored noise, then low/high/low on the echo line
    task automatic push_ranging(input int delay, input int width, input bit start_at_end);
        int trig_n;
        trig_n = (trig_len == 8'd0) ? 1 : int'(trig_len);
        push_tick(1'b1, 1'($urandom_range(1)));
        repeat (trig_n - 1) push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (delay) push_tick(1'b0, 1'b0);
        repeat (width) push_tick(1'b0, 1'b1);
        push_tick(start_at_end, 1'b0);
    endtask

    task automatic push_timeout(input bit echo_stuck);
        int trig_n;
        int listen_n;
        trig_n = (trig_len == 8'd0) ? 1 : int'(trig_len);
        listen_n = (timeout_len == 16'd0) ? 1 : int'(timeout_len);
        push_tick(1'b1, 1'b0);
        repeat (trig_n - 1) push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (listen_n) push_tick(1'b0, echo_stuck);
    endtask

    task automatic settle();
        while (ticks_sent != ticks_queued || exp_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_ranging(input logic [7:0] t, input logic [15:0] to);
        logic [15:0] junk;
        junk = 16'($urandom);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= uer_pkg::CFG_TRIGGER_TICKS;
        cfg_wdata <= {junk[15:8], t};
        @(posedge clk);
        cfg_index <= uer_pkg::CFG_TIMEOUT_TICKS;
        cfg_wdata <= to;
        @(posedge clk);
        cfg_we <= 1'b0;
        trig_len = t;
        timeout_len = to;
        settings_used++;
    endtask

    initial
    begin : stimulus
        int first;
        int lim;
        int sel;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.start_req = 1'b0;
        sample_ch.echo_level = 1'b0;
        result_ch.ready = 1'b0;
        trig_len = uer_pkg::TRIGGER_RESET;
        timeout_len = uer_pkg::TIMEOUT_RESET;
        rng_phase = uer_pkg::PH_IDLE;
        rng_ticks = '0;
        rng_seen = 1'b0;
        rng_dist = '0;
        send_idle_pct = 18;
        recv_idle_pct = 52;
        settings_used = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: idle echo ignored, shortest echo, start on done tick,
        // restart right after done
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        push_ranging(0, 1, 1'b0);
        push_ranging(3, 100, 1'b1);
        push_ranging(5, 2, 1'b0);
        push_idle(2);
        settle();
        // zero trigger length and zero timeout
        set_ranging(8'd0, 16'd0);
        push_timeout(1'b0);
        push_timeout(1'b1);
        push_idle(1);
        settle();
        set_ranging(8'd1, 16'd1);
        push_timeout(1'b1);
        push_ranging(0, 1, 1'b0);
        settle();
        // echo falling edge on the timeout tick wins
        set_ranging(8'd255, 16'd2);
        push_ranging(0, 1, 1'b1);
        push_idle(1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            if (ph == 3)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 18;
            end
            else if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(3) == 0)
                set_ranging(8'($urandom_range(0, 40)), 16'($urandom_range(1, 400)));
            else
                set_ranging(8'($urandom_range(0, 24)), 16'($urandom_range(1, 80)));
            first = ticks_queued;
            while (ticks_queued - first < PHASE_TICKS)
            begin
                sel = $urandom_range(99);
                lim = int'(timeout_len);
                if (lim > 60 && $urandom_range(3) != 0)
                    lim = 60;
                if (sel < 70 || (sel < 80 && timeout_len > 300))
                    push_ranging($urandom_range(0, lim / 2), $urandom_range(1, lim / 2 + 1),
                                 1'($urandom_range(1)));
                else if (sel < 80)
                    push_timeout(1'($urandom_range(1)));
                else if (sel < 90)
                    push_idle($urandom_range(1, 8));
                else
                    repeat ($urandom_range(1, 10))
                        push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                push_idle($urandom_range(0, 3));
            end
            if (ph == 1 || ph == 4)
                hold_asked++;
        end

        // widest timeout setting with an echo past one distance unit
        settle();
        set_ranging(8'd3, 16'd65535);
        push_ranging(296 + $urandom_range(0, 40), 3, 1'b0);
        push_idle(4);

        settle();
        repeat (10) @(posedge clk);
        $display("Ran %0d ticks under %0d register settings: %0d echo measurements, %0d timeouts.",
                 ticks_sent, settings_used, echo_count, timeout_count);
        $display("Largest distance %0d; %0d mismatching result transactions.",
                 max_dist, mismatch_count);
        if (mismatch_count == 0 && exp_results.size() == 0)
            $display("ultrasonic_echo_ranger_unit test passed");
        else
            $display("ultrasonic_echo_ranger_unit test failed");
        $finish;
    end

endmodule
